// File: hdl/lpca_pkg.sv
// Package for the long-press countdown alarm core.
// Holds phase and mode codes, register reset values and the state and result types.
// No dependencies.
package lpca_pkg;

    localparam logic [1:0] PH_WAIT  = 2'd0;
    localparam logic [1:0] PH_READY = 2'd1;
    localparam logic [1:0] PH_PRESS = 2'd2;
    localparam logic [1:0] PH_LONG  = 2'd3;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_ALARM = 2'd2;

    localparam logic [2:0] REG_START_SECONDS     = 3'd0;
    localparam logic [2:0] REG_TICKS_PER_SECOND  = 3'd1;
    localparam logic [2:0] REG_LONG_PRESS_TICKS  = 3'd2;
    localparam logic [2:0] REG_CLICK_MAX_TICKS   = 3'd3;
    localparam logic [2:0] REG_ALARM_LIMIT_TICKS = 3'd4;
    localparam logic [2:0] REG_BEEP_HALF_TICKS   = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 32;

    typedef struct packed {
        logic [11:0] start_seconds;
        logic [9:0]  ticks_per_second;
        logic [9:0]  long_press_ticks;
        logic [9:0]  click_max_ticks;
        logic [15:0] alarm_limit_ticks;
        logic [9:0]  beep_half_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        start_seconds:     12'd180,
        ticks_per_second:  10'd50,
        long_press_ticks:  10'd50,
        click_max_ticks:   10'd15,
        alarm_limit_ticks: 16'd1500,
        beep_half_ticks:   10'd25
    };

    typedef struct packed {
        logic [1:0]  phase;
        logic [9:0]  press_count;
        logic [1:0]  mode;
        logic [11:0] seconds;
        logic [9:0]  second_ticks;
        logic [15:0] alarm_ticks;
        logic [9:0]  beep_ticks;
        logic        beep_flag;
        logic        buzzer;
    } st_t;

    localparam st_t ST_RESET = '{
        phase:        PH_WAIT,
        press_count:  10'd0,
        mode:         MODE_IDLE,
        seconds:      12'd0,
        second_ticks: 10'd0,
        alarm_ticks:  16'd0,
        beep_ticks:   10'd0,
        beep_flag:    1'b0,
        buzzer:       1'b0
    };

    typedef struct packed {
        logic        exit_request;
        logic [1:0]  press_phase;
        logic [9:0]  press_progress;
        logic [11:0] seconds_left;
        logic [1:0]  timer_mode;
        logic        buzzer_on;
    } res_t;

endpackage

// File: hdl/long_press_countdown_alarm_core.sv
// Top level of the long-press countdown alarm core.
// Holds the configuration registers, the tick state and the output register with skid stage.
// Depends on lpca_pkg and lpca_step.
//
// Usage:
//   s_* carries one time-base tick per transaction; s_tdata[0] is the sampled
//   button level. Every accepted tick yields exactly one result on m_*.
//   cfg_* writes one configuration register per transaction (cfg_index selects,
//   cfg_data carries the value, low bits used); cfg_ready is always high.
//   Write configuration only while no tick is in flight.
// Throughput and output:
//   One tick per cycle is accepted while s_tready is high; each result is registered
//   in the output or skid register; the state update is a single register-to-register step.
// Stalls:
//   With m_tready low, one more tick is accepted into a skid register; s_tready
//   drops only while that skid register is full.
// Reset:
//   rst_n low clears all tick state to idle, press phase to wait-release and
//   loads the register defaults (180 s, 50 ticks/s, long press 50, click 15,
//   alarm limit 1500, beep half period 25). No result is pending after reset.
module long_press_countdown_alarm_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] button_down, [7:1] zero
    input  logic [lpca_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] buzzer_on, [2:1] timer_mode, [14:3] seconds_left,
    // [24:15] press_progress, [26:25] press_phase, [27] exit_request, [31:28] zero
    output logic [lpca_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lpca_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lpca_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lpca_pkg::*;

    cfg_t                  cfg_reg;
    st_t                   st_reg;
    st_t                   st_next;
    res_t                  res;
    logic [OUT_DATA_W-1:0] res_data;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] skid_data_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  push;
    logic                  pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~skid_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign push      = s_tvalid & s_tready;
    assign pop       = out_valid_reg & m_tready;
    assign res_data  = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, res};

    lpca_step u_step (
        .st          (st_reg),
        .cfg         (cfg_reg),
        .button_down (s_tdata[0]),
        .st_next     (st_next),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_SECONDS:     cfg_reg.start_seconds     <= cfg_data[11:0];
                REG_TICKS_PER_SECOND:  cfg_reg.ticks_per_second  <= cfg_data[9:0];
                REG_LONG_PRESS_TICKS:  cfg_reg.long_press_ticks  <= cfg_data[9:0];
                REG_CLICK_MAX_TICKS:   cfg_reg.click_max_ticks   <= cfg_data[9:0];
                REG_ALARM_LIMIT_TICKS: cfg_reg.alarm_limit_ticks <= cfg_data;
                REG_BEEP_HALF_TICKS:   cfg_reg.beep_half_ticks   <= cfg_data[9:0];
                default:               cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RESET;
        end
        else if (push)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= res_data;
            end
            else
            begin
                out_data_reg <= res_data;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_alarm_seconds_zero: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.mode == MODE_ALARM |-> st_reg.seconds == '0)
        else $error("seconds nonzero while alarming");

    a_buzzer_only_in_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.buzzer |-> st_reg.mode == MODE_ALARM)
        else $error("buzzer on outside alarm");

    a_exit_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        push && res.exit_request |=> st_reg.mode == MODE_IDLE && st_reg.phase == PH_WAIT)
        else $error("click exit did not clear the block");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry lost on drain");

endmodule

// File: hdl/lpca_step.sv
// Next-state and result logic for one tick of the long-press countdown alarm.
// Press classifier, long-press and click handling, seconds countdown and alarm.
// Depends on lpca_pkg.
module lpca_step (
    input  lpca_pkg::st_t  st,
    input  lpca_pkg::cfg_t cfg,
    input  logic           button_down,
    output lpca_pkg::st_t  st_next,
    output lpca_pkg::res_t res
);
    import lpca_pkg::*;

    always_comb
    begin
        st_t         ns;
        logic        click;
        logic [9:0]  cnt_inc;
        logic [10:0] sec_inc;
        logic [11:0] sec_dec;
        logic [15:0] alarm_inc;
        logic [9:0]  beep_inc;

        ns        = st;
        click     = 1'b0;
        cnt_inc   = (st.press_count != '1) ? st.press_count + 10'd1 : st.press_count;

        unique case (st.phase)
            PH_WAIT, PH_LONG:
            begin
                if (!button_down)
                begin
                    ns.phase       = PH_READY;
                    ns.press_count = '0;
                end
            end
            PH_READY:
            begin
                if (button_down)
                begin
                    ns.phase       = PH_PRESS;
                    ns.press_count = '0;
                end
            end
            PH_PRESS:
            begin
                if (button_down)
                begin
                    ns.press_count = cnt_inc;
                    if (cnt_inc >= cfg.long_press_ticks)
                    begin
                        ns.phase = PH_LONG;
                        priority if (st.mode == MODE_IDLE)
                        begin
                            ns.seconds      = cfg.start_seconds;
                            ns.mode         = MODE_RUN;
                            ns.second_ticks = '0;
                        end
                        else if (st.mode == MODE_RUN)
                        begin
                            ns.mode    = MODE_IDLE;
                            ns.seconds = '0;
                        end
                        else
                        begin
                            ns.buzzer = 1'b0;
                            ns.mode   = MODE_IDLE;
                        end
                    end
                end
                else if (st.press_count != '0 && st.press_count <= cfg.click_max_ticks)
                begin
                    click = 1'b1;
                end
                else
                begin
                    ns.phase       = PH_READY;
                    ns.press_count = '0;
                end
            end
            default:
            begin
                ns = st;
            end
        endcase

        sec_inc   = {1'b0, ns.second_ticks} + 11'd1;
        sec_dec   = (ns.seconds != '0) ? ns.seconds - 12'd1 : ns.seconds;
        alarm_inc = (ns.alarm_ticks != '1) ? ns.alarm_ticks + 16'd1 : ns.alarm_ticks;
        beep_inc  = (ns.beep_ticks != '1) ? ns.beep_ticks + 10'd1 : ns.beep_ticks;

        if (click)
        begin
            ns           = ST_RESET;
            ns.beep_flag = st.beep_flag;
        end
        else if (ns.mode == MODE_RUN)
        begin
            if (sec_inc >= {1'b0, cfg.ticks_per_second})
            begin
                ns.second_ticks = '0;
                ns.seconds      = sec_dec;
                if (sec_dec == '0)
                begin
                    ns.mode        = MODE_ALARM;
                    ns.buzzer      = 1'b1;
                    ns.alarm_ticks = '0;
                    ns.beep_ticks  = '0;
                end
            end
            else
            begin
                ns.second_ticks = sec_inc[9:0];
            end
        end
        else if (ns.mode == MODE_ALARM)
        begin
            ns.alarm_ticks = alarm_inc;
            ns.beep_ticks  = beep_inc;
            if (alarm_inc > cfg.alarm_limit_ticks)
            begin
                ns.buzzer = 1'b0;
                ns.mode   = MODE_IDLE;
            end
            else if (alarm_inc == 16'd1 || beep_inc > cfg.beep_half_ticks)
            begin
                ns.beep_flag  = ~ns.beep_flag;
                ns.buzzer     = ns.beep_flag;
                ns.beep_ticks = '0;
            end
        end

        st_next            = ns;
        res.buzzer_on      = ns.buzzer;
        res.timer_mode     = ns.mode;
        res.seconds_left   = ns.seconds;
        res.press_progress = ns.press_count;
        res.press_phase    = ns.phase;
        res.exit_request   = click;
    end

endmodule

// File: dv/lpca_tick_checker.sv
// Checker for the long-press countdown alarm core: watches the tick, result and register channels.
// Predicts each result from its own copy of the registers and tick state and compares field by field.
// Depends on lpca_pkg.
module lpca_tick_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [lpca_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [lpca_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [lpca_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpca_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               pending
);
    import lpca_pkg::*;

    localparam int RES_W = $bits(res_t);

    cfg_t alarm_regs;
    st_t  alarm_state;
    res_t predicted_results [$];

    function automatic res_t visible_state(input logic exit_flag);
        res_t r;
        r.buzzer_on      = alarm_state.buzzer;
        r.timer_mode     = alarm_state.mode;
        r.seconds_left   = alarm_state.seconds;
        r.press_progress = alarm_state.press_count;
        r.press_phase    = alarm_state.phase;
        r.exit_request   = exit_flag;
        return r;
    endfunction

    function automatic res_t predict_tick(input logic down);
        logic click_exit;
        logic kept_beep;
        int   next_second_ticks;
        click_exit = 1'b0;
        case (alarm_state.phase)
            PH_WAIT:
            begin
                if (!down)
                begin
                    alarm_state.phase       = PH_READY;
                    alarm_state.press_count = '0;
                end
            end
            PH_READY:
            begin
                if (down)
                begin
                    alarm_state.phase       = PH_PRESS;
                    alarm_state.press_count = '0;
                end
            end
            PH_PRESS:
            begin
                if (down)
                begin
                    if (alarm_state.press_count != 10'd1023)
                        alarm_state.press_count = alarm_state.press_count + 10'd1;
                    if (alarm_state.press_count >= alarm_regs.long_press_ticks)
                    begin
                        alarm_state.phase = PH_LONG;
                        case (alarm_state.mode)
                            MODE_IDLE:
                            begin
                                alarm_state.seconds      = alarm_regs.start_seconds;
                                alarm_state.mode         = MODE_RUN;
                                alarm_state.second_ticks = '0;
                            end
                            MODE_RUN:
                            begin
                                alarm_state.mode    = MODE_IDLE;
                                alarm_state.seconds = '0;
                            end
                            default:
                            begin
                                alarm_state.buzzer = 1'b0;
                                alarm_state.mode   = MODE_IDLE;
                            end
                        endcase
                    end
                end
                else if (alarm_state.press_count != 10'd0 &&
                         alarm_state.press_count <= alarm_regs.click_max_ticks)
                begin
                    click_exit = 1'b1;
                end
                else
                begin
                    alarm_state.phase       = PH_READY;
                    alarm_state.press_count = '0;
                end
            end
            default:
            begin
                if (!down)
                begin
                    alarm_state.phase       = PH_READY;
                    alarm_state.press_count = '0;
                end
            end
        endcase

        // Click exit: clear everything but the beep flag and skip the countdown.
        if (click_exit)
        begin
            kept_beep             = alarm_state.beep_flag;
            alarm_state           = ST_RESET;
            alarm_state.beep_flag = kept_beep;
            return visible_state(1'b1);
        end

        if (alarm_state.mode == MODE_RUN)
        begin
            next_second_ticks = int'(alarm_state.second_ticks) + 1;
            if (next_second_ticks >= int'(alarm_regs.ticks_per_second))
            begin
                alarm_state.second_ticks = '0;
                if (alarm_state.seconds != 12'd0)
                    alarm_state.seconds = alarm_state.seconds - 12'd1;
                if (alarm_state.seconds == 12'd0)
                begin
                    alarm_state.mode        = MODE_ALARM;
                    alarm_state.buzzer      = 1'b1;
                    alarm_state.alarm_ticks = '0;
                    alarm_state.beep_ticks  = '0;
                end
            end
            else
            begin
                alarm_state.second_ticks = next_second_ticks[9:0];
            end
        end
        else if (alarm_state.mode == MODE_ALARM)
        begin
            if (alarm_state.alarm_ticks != 16'hFFFF)
                alarm_state.alarm_ticks = alarm_state.alarm_ticks + 16'd1;
            if (alarm_state.beep_ticks != 10'd1023)
                alarm_state.beep_ticks = alarm_state.beep_ticks + 10'd1;
            if (alarm_state.alarm_ticks > alarm_regs.alarm_limit_ticks)
            begin
                alarm_state.buzzer = 1'b0;
                alarm_state.mode   = MODE_IDLE;
            end
            else if (alarm_state.alarm_ticks == 16'd1 ||
                     alarm_state.beep_ticks > alarm_regs.beep_half_ticks)
            begin
                alarm_state.beep_flag  = ~alarm_state.beep_flag;
                alarm_state.buzzer     = alarm_state.beep_flag;
                alarm_state.beep_ticks = '0;
            end
        end
        return visible_state(1'b0);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            alarm_regs  = CFG_RESET;
            alarm_state = ST_RESET;
            predicted_results.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_START_SECONDS:     alarm_regs.start_seconds     = cfg_data[11:0];
                    REG_TICKS_PER_SECOND:  alarm_regs.ticks_per_second  = cfg_data[9:0];
                    REG_LONG_PRESS_TICKS:  alarm_regs.long_press_ticks  = cfg_data[9:0];
                    REG_CLICK_MAX_TICKS:   alarm_regs.click_max_ticks   = cfg_data[9:0];
                    REG_ALARM_LIMIT_TICKS: alarm_regs.alarm_limit_ticks = cfg_data[15:0];
                    REG_BEEP_HALF_TICKS:   alarm_regs.beep_half_ticks   = cfg_data[9:0];
                    default: ;
                endcase
            end

            // Compare the result transaction before queuing this edge's tick.
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h with no tick outstanding", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    got  = m_tdata[RES_W-1:0];
                    if (got.buzzer_on !== want.buzzer_on ||
                        got.timer_mode !== want.timer_mode ||
                        got.seconds_left !== want.seconds_left ||
                        got.press_progress !== want.press_progress ||
                        got.press_phase !== want.press_phase ||
                        got.exit_request !== want.exit_request ||
                        m_tdata[OUT_DATA_W-1:RES_W] !== '0)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch: expected buzzer=%0d mode=%0d secs=%0d ",
                                      "progress=%0d phase=%0d exit=%0d, got buzzer=%0d ",
                                      "mode=%0d secs=%0d progress=%0d phase=%0d exit=%0d ",
                                      "pad=%h"},
                                     want.buzzer_on, want.timer_mode, want.seconds_left,
                                     want.press_progress, want.press_phase, want.exit_request,
                                     got.buzzer_on, got.timer_mode, got.seconds_left,
                                     got.press_progress, got.press_phase, got.exit_request,
                                     m_tdata[OUT_DATA_W-1:RES_W]);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                predicted_results.push_back(predict_tick(s_tdata[0]));

            pending = predicted_results.size();
        end
    end

endmodule

// File: dv/testbench.sv
// Top of the long-press countdown alarm core testbench: clock, reset, tick and register stimulus.
// Runs directed tick patterns, then press sequences under several register settings.
// Depends on lpca_pkg, long_press_countdown_alarm_core and lpca_tick_checker.
module testbench;
    import lpca_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int   fail_count;
    int   pending;
    int   cycle_count;
    int   ticks_sent;
    bit   send_calm;
    bit   recv_calm;
    cfg_t active_regs;

    long_press_countdown_alarm_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lpca_tick_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cfg_t regs_of(input int start_s, input int tps, input int long_t,
                                     input int click_t, input int limit_t, input int beep_t);
        cfg_t r;
        r.start_seconds     = start_s[11:0];
        r.ticks_per_second  = tps[9:0];
        r.long_press_ticks  = long_t[9:0];
        r.click_max_ticks   = click_t[9:0];
        r.alarm_limit_ticks = limit_t[15:0];
        r.beep_half_ticks   = beep_t[9:0];
        return r;
    endfunction

    task automatic send_tick(input logic down);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-1){1'b0}}, down};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic play_bits(input logic [31:0] pattern, input int count);
        for (int i = count - 1; i >= 0; i--)
            send_tick(pattern[i]);
    endtask

    task automatic play_press(input int hold);
        repeat (hold) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic play_release(input int count);
        repeat (count) send_tick(1'b0);
    endtask

    // Drop any press in progress, then click out so the block is idle and ready.
    task automatic return_to_idle();
        play_release(2);
        play_press(2);
        play_release(1);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_regs(input cfg_t values);
        logic [CFG_INDEX_W-1:0] reg_order [6];
        reg_order = '{REG_START_SECONDS, REG_TICKS_PER_SECOND, REG_LONG_PRESS_TICKS,
                      REG_CLICK_MAX_TICKS, REG_ALARM_LIMIT_TICKS, REG_BEEP_HALF_TICKS};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_order[i];
            case (reg_order[i])
                REG_START_SECONDS:     cfg_data <= CFG_DATA_W'(values.start_seconds);
                REG_TICKS_PER_SECOND:  cfg_data <= CFG_DATA_W'(values.ticks_per_second);
                REG_LONG_PRESS_TICKS:  cfg_data <= CFG_DATA_W'(values.long_press_ticks);
                REG_CLICK_MAX_TICKS:   cfg_data <= CFG_DATA_W'(values.click_max_ticks);
                REG_ALARM_LIMIT_TICKS: cfg_data <= CFG_DATA_W'(values.alarm_limit_ticks);
                default:               cfg_data <= CFG_DATA_W'(values.beep_half_ticks);
            endcase
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        active_regs = values;
    endtask

    // Mostly clicks, long presses and release runs; the rest random button noise.
    task automatic run_random(input int count);
        int stop;
        int pick;
        stop = ticks_sent + count;
        while (ticks_sent < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                play_press($urandom_range(1, int'(active_regs.click_max_ticks) + 2));
            else if (pick < 55)
                play_press(int'(active_regs.long_press_ticks) + $urandom_range(1, 4));
            else if (pick < 80)
                play_release($urandom_range(1, 12));
            else
                repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        m_tready  = 1'b1;
        recv_calm = 1'b0;
        forever
        begin
            int stall;
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                @(negedge clk);
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                stall = recv_calm ? 0 : $urandom_range(0, 15);
                if (stall != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        ticks_sent  = 0;
        send_calm   = 1'b0;
        active_regs = CFG_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset registers: short tap, click exit, press ignored while waiting for release.
        play_bits(32'b01011010, 8);
        settle();

        // All-zero registers: immediate long press, zero-length countdown, one-tick alarm.
        write_regs(regs_of(0, 0, 0, 0, 0, 0));
        play_bits(32'b1110, 4);
        settle();

        // Start, stop, restart, alarm entry and silencing by long press.
        write_regs(regs_of(2, 2, 1, 0, 65535, 1023));
        play_bits(32'b110110111110110, 15);
        settle();

        write_regs(regs_of(3, 2, 4, 3, 20, 3));
        run_random(130);
        settle();

        write_regs(regs_of(1, 1, 1, 1, 1, 1));
        run_random(90);
        settle();

        write_regs(regs_of(5, 3, 2, 6, 60, 2));
        run_random(130);
        settle();

        repeat (2)
        begin
            write_regs(regs_of($urandom_range(0, 6), $urandom_range(0, 4),
                               $urandom_range(0, 8), $urandom_range(0, 6),
                               $urandom_range(0, 80), $urandom_range(0, 8)));
            run_random(90);
            settle();
        end

        // Countdown from 3599 seconds at the slowest second.
        write_regs(regs_of(3599, 1023, 2, 3, 65535, 1023));
        return_to_idle();
        play_press(3);
        run_random(90);
        settle();

        // Wide press and click windows, then a long alarm silenced by a long press.
        write_regs(regs_of(1, 1, 60, 60, 65535, 1023));
        return_to_idle();
        play_press(61);
        play_release(80);
        play_press(61);
        play_press(40);
        settle();

        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
